FILE: hw/rtl/rtt_pkg.sv
// ----------------------------------------------------------------------------
// rtt_pkg
// Shared types, sizes and codes of the redundant real-time-text receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package rtt_pkg;

  localparam int unsigned BUFFER_BYTES    = 64;
  localparam int unsigned MAX_GENERATIONS = 8;
  localparam int unsigned MAX_BLOCK_LEN   = 1023;
  localparam int unsigned LATE_LIMIT      = 100;

  localparam int unsigned BUF_AW = $clog2(BUFFER_BYTES);
  localparam int unsigned FILL_W = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned GEN_W  = $clog2(MAX_GENERATIONS + 1);
  localparam int unsigned SUM_W  = $clog2(MAX_GENERATIONS * MAX_BLOCK_LEN + 1);

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_ORDER  = 3'd1;
  localparam logic [2:0] ST_HEADER = 3'd2;
  localparam logic [2:0] ST_UTF8   = 3'd3;
  localparam logic [2:0] ST_LENGTH = 3'd4;

  localparam logic CFG_TEXT_PT = 1'b0;
  localparam logic CFG_RED_PT  = 1'b1;

  localparam logic [20:0] BOM_CODE = 21'h00FEFF;

  typedef enum logic [2:0] {
    CLS_CONT,
    CLS_ONE,
    CLS_TWO,
    CLS_THREE,
    CLS_FOUR,
    CLS_BAD
  } byte_class_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        byte_present;
    logic [15:0] sequence_number;
    logic        first_of_packet;
    logic        last_of_packet;
  } in_item_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        char_valid;
    logic [2:0]  packet_status;
    logic        last_result;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [FILL_W-1:0] fill;
    logic              repl;
    logic [2:0]        status;
  } emit_start_t;

  function automatic byte_class_e byte_class(input logic [7:0] b);
    byte_class_e c;
    if (!b[7]) c = CLS_ONE;
    else if (!b[6]) c = CLS_CONT;
    else if (!b[5]) c = CLS_TWO;
    else if (!b[4]) c = CLS_THREE;
    else if (!b[3]) c = CLS_FOUR;
    else c = CLS_BAD;
    return c;
  endfunction

  // Bytes of U+FFFD that stand virtually at the head of the buffer.
  function automatic logic [7:0] repl_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = 8'hEF;
      2'd1:    r = 8'hBF;
      default: r = 8'hBD;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rtt_ram.sv
// ----------------------------------------------------------------------------
// rtt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rtt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rtt_emit.sv
// ----------------------------------------------------------------------------
// rtt_emit
// Walks the text buffer after a packet closes and emits decoded code points.
// ----------------------------------------------------------------------------
`default_nettype none

module rtt_emit import rtt_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire emit_start_t       start_i,
  output logic                   busy_o,
  output logic                   re_o,
  output logic [BUF_AW-1:0]      raddr_o,
  input  wire logic [7:0]        rdata_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output out_item_t              out_data_o
);

  typedef enum logic [1:0] {E_IDLE, E_RD, E_WT, E_FIN} emit_state_e;

  emit_state_e       state_q, state_d;
  logic [FILL_W-1:0] p_q, p_d, fill_q, fill_d;
  logic              repl_q, repl_d;
  logic [2:0]        err_q, err_d;
  logic [1:0]        rem_q, rem_d;
  logic              is3_q, is3_d;
  logic [20:0]       acc_q, acc_d;
  logic              hv_q, hv_d;
  logic [20:0]       hold_q, hold_d;
  logic              ov_q, ov_d;
  out_item_t         out_q, out_d;

  logic              can_push;
  logic [7:0]        cur_byte;
  logic              done;
  logic [20:0]       val;
  byte_class_e       cls;

  assign can_push = !ov_q || !out_stall_i;
  assign busy_o   = (state_q != E_IDLE);
  assign raddr_o  = p_q[BUF_AW-1:0];
  assign re_o     = (state_q == E_RD) && (p_q < fill_q);
  assign cur_byte = (repl_q && p_q < FILL_W'(3)) ? repl_byte(p_q[1:0]) : rdata_i;
  assign cls      = byte_class(cur_byte);

  always_comb begin
    state_d = state_q;
    p_d     = p_q;
    fill_d  = fill_q;
    repl_d  = repl_q;
    err_d   = err_q;
    rem_d   = rem_q;
    is3_d   = is3_q;
    acc_d   = acc_q;
    hv_d    = hv_q;
    hold_d  = hold_q;
    ov_d    = ov_q && out_stall_i;
    out_d   = out_q;
    done    = 1'b0;
    val     = '0;

    case (state_q)
      E_IDLE: begin
        if (start_i.start) begin
          fill_d  = start_i.fill;
          repl_d  = start_i.repl;
          err_d   = start_i.status;
          p_d     = '0;
          rem_d   = '0;
          hv_d    = 1'b0;
          state_d = E_RD;
        end
      end
      E_RD: begin
        if (p_q < fill_q) begin
          state_d = E_WT;
        end else begin
          state_d = E_FIN;
        end
      end
      E_WT: begin
        if (rem_q == 2'd0) begin
          if (cur_byte == 8'h00) begin
            p_d     = p_q + 1'b1;
            state_d = E_RD;
          end else begin
            is3_d = 1'b0;
            case (cls)
              CLS_ONE: begin
                done = 1'b1;
                val  = {13'd0, cur_byte};
              end
              CLS_TWO: begin
                acc_d   = {16'd0, cur_byte[4:0]};
                rem_d   = 2'd1;
                p_d     = p_q + 1'b1;
                state_d = E_RD;
              end
              CLS_THREE: begin
                acc_d   = {17'd0, cur_byte[3:0]};
                rem_d   = 2'd2;
                is3_d   = 1'b1;
                p_d     = p_q + 1'b1;
                state_d = E_RD;
              end
              CLS_FOUR: begin
                acc_d   = {18'd0, cur_byte[2:0]};
                rem_d   = 2'd3;
                p_d     = p_q + 1'b1;
                state_d = E_RD;
              end
              default: begin
                state_d = E_FIN;
              end
            endcase
          end
        end else begin
          if (rem_q == 2'd1) begin
            done = 1'b1;
            val  = {acc_q[14:0], cur_byte[5:0]};
          end else begin
            acc_d   = {acc_q[14:0], cur_byte[5:0]};
            rem_d   = rem_q - 1'b1;
            p_d     = p_q + 1'b1;
            state_d = E_RD;
          end
        end

        if (done) begin
          if (val == '0) begin
            // An overlong zero ends the packet's text.
            state_d = E_FIN;
          end else if (is3_q && rem_q != 2'd0 && val == BOM_CODE) begin
            rem_d   = '0;
            p_d     = p_q + 1'b1;
            state_d = E_RD;
          end else if (!hv_q || can_push) begin
            if (hv_q) begin
              ov_d  = 1'b1;
              out_d = '{code_point: hold_q, char_valid: 1'b1,
                        packet_status: err_q, last_result: 1'b0};
            end
            hv_d    = 1'b1;
            hold_d  = val;
            rem_d   = '0;
            p_d     = p_q + 1'b1;
            state_d = E_RD;
          end
        end
      end
      E_FIN: begin
        if (can_push) begin
          ov_d    = 1'b1;
          out_d   = '{code_point: hv_q ? hold_q : 21'd0, char_valid: hv_q,
                      packet_status: err_q, last_result: 1'b1};
          hv_d    = 1'b0;
          state_d = E_IDLE;
        end
      end
      default: begin
        state_d = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      p_q     <= '0;
      fill_q  <= '0;
      repl_q  <= 1'b0;
      err_q   <= ST_OK;
      rem_q   <= '0;
      is3_q   <= 1'b0;
      hv_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      p_q     <= p_d;
      fill_q  <= fill_d;
      repl_q  <= repl_d;
      err_q   <= err_d;
      rem_q   <= rem_d;
      is3_q   <= is3_d;
      hv_q    <= hv_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    hold_q <= hold_d;
    out_q  <= out_d;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  // A character is only held back while a packet is being drained.
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == E_IDLE |-> !hv_q)
    else $error("held character outside emission");

  // The read pointer never passes the buffer fill.
  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != E_IDLE |-> p_q <= fill_q)
    else $error("read pointer past fill");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/rtt_redundant_text_receiver_top.sv
// Results: an empty buffer gives a single result once the packet's last request is taken;
// otherwise the first result waits until a second character is decoded or the buffer end is
// reached, each buffered byte passing a read state and a wait state for the registered read
// port of the text buffer memory. Throughput: one byte request per cycle while a packet
// arrives; requests stall while the buffer is drained, longer under result stalls.
// Reset: asynchronous active low; clears all control state, the buffer is not cleared.
// ----------------------------------------------------------------------------
// rtt_redundant_text_receiver_top
// Real-time-text receiver with redundancy header parsing, loss marking,
// UTF-8 checking and code point emission.
// ----------------------------------------------------------------------------
`default_nettype none

module rtt_redundant_text_receiver_top import rtt_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire in_item_t   in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output out_item_t       out_data_o,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [6:0] cfg_wdata_i
);

  typedef enum logic [2:0] {PH_IDLE, PH_TEXT, PH_HEAD, PH_DATA, PH_DROP} phase_e;

  phase_e            ph_q, ph_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [GEN_W-1:0]  gc_q, gc_d;
  logic [1:0]        bpos_q, bpos_d;
  logic [SUM_W-1:0]  skip_q, skip_d;
  logic [1:0]        pend_q, pend_d;
  logic [2:0]        err_q, err_d;
  logic [15:0]       cur_q, cur_d;
  logic [15:0]       prev_q, prev_d;
  logic              seen_q, seen_d;
  logic              repl_q, repl_d;
  logic [6:0]        tpt_q, rpt_q;
  logic [1:0]        hi_q, hi_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [SUM_W-1:0]  cum_q [1:MAX_GENERATIONS];
  logic              cum_we;
  logic [GEN_W-1:0]  cum_idx;

  logic              in_acc;
  logic              emit_busy;
  emit_start_t       emit_start;
  logic              ram_we, ram_re;
  logic [BUF_AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  function automatic logic signed [17:0] missing(input logic [15:0] cur,
                                                  input logic [15:0] prev);
    logic signed [17:0] d;
    logic signed [17:0] m;
    d = $signed({2'b00, cur}) - $signed({2'b00, prev});
    if (d > 18'sd0) m = d - 18'sd1;
    else if (d < -$signed(18'(LATE_LIMIT))) m = d + 18'sd65535;
    else m = -18'sd1;
    return m;
  endfunction

  assign in_stall_o = emit_busy;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    logic signed [17:0] need;
    logic [GEN_W-1:0]   n;
    logic [7:0]         b;
    byte_class_e        cls;
    logic               bad;

    ph_d      = ph_q;
    fill_d    = fill_q;
    gc_d      = gc_q;
    bpos_d    = bpos_q;
    skip_d    = skip_q;
    pend_d    = pend_q;
    err_d     = err_q;
    cur_d     = cur_q;
    prev_d    = prev_q;
    seen_d    = seen_q;
    repl_d    = repl_q;
    hi_d      = hi_q;
    sum_d     = sum_q;
    cum_we    = 1'b0;
    cum_idx   = gc_q;
    ram_we    = 1'b0;
    ram_waddr = fill_q[BUF_AW-1:0];
    b         = in_data_i.data_byte;
    ram_wdata = b;
    cls       = byte_class(b);
    need      = '0;
    n         = '0;
    bad       = 1'b0;
    emit_start = '{start: 1'b0, fill: fill_q, repl: repl_q, status: err_q};

    if (in_acc) begin
      if (in_data_i.first_of_packet || ph_q == PH_IDLE) begin
        fill_d = '0;
        gc_d   = '0;
        bpos_d = '0;
        skip_d = '0;
        pend_d = '0;
        err_d  = ST_OK;
        repl_d = 1'b0;
        sum_d  = '0;
        cur_d  = in_data_i.sequence_number;
        if (rpt_q != 7'd0) begin
          ph_d = PH_HEAD;
        end else begin
          ph_d = PH_TEXT;
          if (seen_q) begin
            need = missing(in_data_i.sequence_number, prev_q);
            if (need < 18'sd0) begin
              err_d  = ST_ORDER;
              ph_d   = PH_DROP;
            end else if (need > 18'sd0) begin
              repl_d = 1'b1;
              fill_d = FILL_W'(3);
            end
          end
        end
      end

      if (in_data_i.byte_present) begin
        case (ph_d)
          PH_HEAD: begin
            if (bpos_d == 2'd0) begin
              if (b[7]) begin
                if (gc_d >= GEN_W'(MAX_GENERATIONS) || b[6:0] != tpt_q) begin
                  err_d  = ST_HEADER;
                  ph_d   = PH_DROP;
                  fill_d = '0;
                end else begin
                  gc_d = gc_d + 1'b1;
                end
              end else if (b[6:0] != tpt_q) begin
                err_d  = ST_HEADER;
                ph_d   = PH_DROP;
                fill_d = '0;
              end else begin
                // Primary header: decide how many redundant blocks to skip.
                if (seen_q) need = missing(cur_d, prev_q);
                if (need < 18'sd0) begin
                  err_d  = ST_ORDER;
                  ph_d   = PH_DROP;
                  fill_d = '0;
                end else begin
                  if (need > $signed({{(18 - GEN_W){1'b0}}, gc_d})) begin
                    repl_d = 1'b1;
                    fill_d = FILL_W'(3);
                    n      = '0;
                  end else begin
                    n = gc_d - need[GEN_W-1:0];
                  end
                  skip_d = (n == '0) ? '0 : cum_q[n];
                  ph_d   = PH_DATA;
                end
              end
            end else if (gc_d != '0) begin
              if (bpos_d == 2'd2) begin
                hi_d = b[1:0];
              end else if (bpos_d == 2'd3) begin
                sum_d   = sum_q + SUM_W'({hi_q, b});
                cum_we  = 1'b1;
                cum_idx = gc_d;
              end
            end
          end
          PH_TEXT, PH_DATA: begin
            if (skip_d != '0) begin
              skip_d = skip_d - 1'b1;
            end else if (fill_d < FILL_W'(BUFFER_BYTES)) begin
              if (pend_d == 2'd0) begin
                case (cls)
                  CLS_ONE:   pend_d = 2'd0;
                  CLS_TWO:   pend_d = 2'd1;
                  CLS_THREE: pend_d = 2'd2;
                  CLS_FOUR:  pend_d = 2'd3;
                  default:   bad    = 1'b1;
                endcase
              end else if (cls != CLS_CONT) begin
                bad = 1'b1;
              end else begin
                pend_d = pend_d - 1'b1;
              end
              if (bad) begin
                err_d  = ST_UTF8;
                ph_d   = PH_DROP;
                fill_d = '0;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = fill_d[BUF_AW-1:0];
                fill_d    = fill_d + 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
        bpos_d = bpos_d + 1'b1;
      end

      if (in_data_i.last_of_packet) begin
        if (ph_d == PH_HEAD && err_d == ST_OK) begin
          err_d  = ST_HEADER;
          fill_d = '0;
        end
        if (ph_d == PH_DATA && skip_d != '0) err_d = ST_LENGTH;
        if ((ph_d == PH_TEXT || ph_d == PH_DATA) && err_d == ST_OK &&
            pend_d != 2'd0) begin
          err_d  = ST_UTF8;
          fill_d = '0;
        end
        if (err_d == ST_OK) prev_d = cur_d;
        seen_d = 1'b1;
        ph_d   = PH_IDLE;
        emit_start = '{start: 1'b1, fill: fill_d, repl: repl_d, status: err_d};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      fill_q <= '0;
      gc_q   <= '0;
      bpos_q <= '0;
      skip_q <= '0;
      pend_q <= '0;
      err_q  <= ST_OK;
      cur_q  <= '0;
      prev_q <= '0;
      seen_q <= 1'b0;
      repl_q <= 1'b0;
      sum_q  <= '0;
      tpt_q  <= '0;
      rpt_q  <= '0;
    end else begin
      ph_q   <= ph_d;
      fill_q <= fill_d;
      gc_q   <= gc_d;
      bpos_q <= bpos_d;
      skip_q <= skip_d;
      pend_q <= pend_d;
      err_q  <= err_d;
      cur_q  <= cur_d;
      prev_q <= prev_d;
      seen_q <= seen_d;
      repl_q <= repl_d;
      sum_q  <= sum_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TEXT_PT: tpt_q <= cfg_wdata_i;
          CFG_RED_PT:  rpt_q <= cfg_wdata_i;
          default:     tpt_q <= tpt_q;
        endcase
      end
    end
  end

  // Running prefix sums of the redundant block lengths.
  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    if (cum_we) begin
      cum_q[cum_idx] <= sum_d;
    end
  end

  rtt_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_BYTES)
  ) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rtt_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (emit_start),
    .busy_o      (emit_busy),
    .re_o        (ram_re),
    .raddr_o     (ram_raddr),
    .rdata_i     (ram_rdata),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTH
  // Closing a packet always hands the buffer to the emitter.
  a_close_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.last_of_packet |=> emit_busy && ph_q == PH_IDLE)
    else $error("packet close did not start emission");

  // The fill never passes the buffer capacity.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(BUFFER_BYTES))
    else $error("buffer fill out of range");
`endif

endmodule

`default_nettype wire

FILE: dv/tb_rtt_redundant_text_receiver_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rtt_redundant_text_receiver_top
// Drives real-time-text packets, in plain and redundant mode, into the
// receiver, predicts the code points and packet status of each packet, and
// compares every result against the predicted queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rtt_redundant_text_receiver_top;
  import rtt_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;

  typedef enum logic [2:0] {
    PH_IDLE, PH_TEXT, PH_HEAD, PH_DATA, PH_DROP
  } parse_phase_e;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic      cfg_we_i = 1'b0;
  logic      cfg_idx_i = CFG_TEXT_PT;
  logic [6:0] cfg_wdata_i = '0;

  rtt_redundant_text_receiver_top i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state.
  logic [6:0]  text_pt, red_pt;
  logic [7:0]  txt_buf [BUFFER_BYTES];
  int unsigned fill, prev_seq, cur_seq, gen_cnt, byte_pos, skip_left, pending, pkt_err;
  bit          seen_first;
  int unsigned gen_len [MAX_GENERATIONS];
  parse_phase_e phase;

  out_item_t   char_queue[$];
  int          errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned packets_sent = 0;
  bit          rx_random = 1'b1;
  bit          tx_random = 1'b1;

  function automatic int classify(logic [7:0] c);
    if (!c[7]) return 1;
    if (!c[6]) return 0;
    if (!c[5]) return 2;
    if (!c[4]) return 3;
    if (!c[3]) return 4;
    return -1;
  endfunction

  function automatic int gap_of(int unsigned cur, int unsigned prev);
    int d;
    d = int'(cur) - int'(prev);
    if (d > 0) return d - 1;
    if (d < -100) return d + 'hFFFF;
    return -1;
  endfunction

  function automatic void mark_loss();
    txt_buf[0] = 8'hEF; txt_buf[1] = 8'hBF; txt_buf[2] = 8'hBD;
    fill = 3;
  endfunction

  function automatic void drop_packet(int unsigned code);
    pkt_err = code;
    phase = PH_DROP;
    fill = 0;
  endfunction

  function automatic void keep_text(logic [7:0] b);
    int t;
    if (fill >= BUFFER_BYTES) return;
    t = classify(b);
    if (pending == 0) begin
      if (t <= 0) begin drop_packet(ST_UTF8); return; end
      pending = t - 1;
    end else begin
      if (t != 0) begin drop_packet(ST_UTF8); return; end
      pending--;
    end
    txt_buf[fill] = b;
    fill++;
  endfunction

  function automatic void settle_generations();
    int need;
    int unsigned n, sum;
    need = 0;
    sum = 0;
    if (seen_first) need = gap_of(cur_seq, prev_seq);
    if (need < 0) begin drop_packet(ST_ORDER); return; end
    if (need > int'(gen_cnt)) begin
      mark_loss();
      need = gen_cnt;
    end
    n = gen_cnt - need;
    for (int unsigned i = 0; i < n && i < MAX_GENERATIONS; i++) sum += gen_len[i] & 'h3FF;
    skip_left = sum;
    phase = PH_DATA;
  endfunction

  function automatic void parse_header(logic [7:0] b);
    int unsigned r;
    r = byte_pos & 3;
    if (r == 0) begin
      if (b[7]) begin
        if (gen_cnt >= MAX_GENERATIONS || b[6:0] != text_pt) begin
          drop_packet(ST_HEADER); return;
        end
        gen_cnt++;
      end else begin
        if (b != {1'b0, text_pt}) begin drop_packet(ST_HEADER); return; end
        settle_generations();
      end
    end else if (gen_cnt > 0 && gen_cnt <= MAX_GENERATIONS) begin
      if (r == 2) gen_len[gen_cnt-1] = (b & 3) << 8;
      else if (r == 3) gen_len[gen_cnt-1] |= b;
    end
  endfunction

  function automatic void open_packet(int unsigned seq);
    int t;
    fill = 0; gen_cnt = 0; byte_pos = 0; skip_left = 0; pending = 0; pkt_err = 0;
    cur_seq = seq;
    if (red_pt > 0) phase = PH_HEAD;
    else begin
      phase = PH_TEXT;
      if (seen_first) begin
        t = gap_of(seq, prev_seq);
        if (t < 0) drop_packet(ST_ORDER);
        else if (t > 0) mark_loss();
      end
    end
  endfunction

  function automatic int unsigned next_byte(ref int unsigned p);
    int unsigned c;
    while (p < fill) begin
      c = txt_buf[p];
      if (c != 0) begin
        if (fill - p >= 3 && c == 'hEF && txt_buf[p+1] == 8'hBB && txt_buf[p+2] == 8'hBF) begin
          p += 3;
          continue;
        end
        p++;
        return c;
      end
      p++;
    end
    return 0;
  endfunction

  function automatic void close_packet();
    int unsigned p, c, n;
    out_item_t r;
    p = 0; n = 0;
    if (phase == PH_HEAD && pkt_err == 0) drop_packet(ST_HEADER);
    if (phase == PH_DATA && skip_left > 0) pkt_err = ST_LENGTH;
    if ((phase == PH_TEXT || phase == PH_DATA) && pkt_err == 0 && pending != 0) begin
      pkt_err = ST_UTF8;
      fill = 0;
    end
    if (pkt_err == 0) prev_seq = cur_seq;
    seen_first = 1'b1;
    phase = PH_IDLE;
    while (n < 64 && p < fill) begin
      c = next_byte(p);
      case (classify(c[7:0]))
        1: ;
        2: c = ((c & 'h1F) << 6) + (next_byte(p) & 'h3F);
        3: begin
          c = (c & 'h0F) << 12;
          c += (next_byte(p) & 'h3F) << 6;
          c += next_byte(p) & 'h3F;
        end
        4: begin
          c = (c & 'h07) << 18;
          c += (next_byte(p) & 'h3F) << 12;
          c += (next_byte(p) & 'h3F) << 6;
          c += next_byte(p) & 'h3F;
        end
        default: c = 0;
      endcase
      if (c == 0) break;
      r.code_point = c[20:0];
      r.char_valid = 1'b1;
      r.packet_status = pkt_err[2:0];
      r.last_result = 1'b0;
      char_queue.push_back(r);
      n++;
    end
    if (n == 0) begin
      r = '0;
      r.packet_status = pkt_err[2:0];
      r.last_result = 1'b1;
      char_queue.push_back(r);
    end else begin
      char_queue[char_queue.size()-1].last_result = 1'b1;
    end
  endfunction

  function automatic void predict_request(in_item_t it);
    if (it.first_of_packet || phase == PH_IDLE) open_packet(it.sequence_number);
    if (it.byte_present) begin
      if (phase == PH_HEAD) parse_header(it.data_byte);
      else if (phase == PH_TEXT || phase == PH_DATA) begin
        if (skip_left > 0) skip_left--;
        else keep_text(it.data_byte);
      end
      if (byte_pos < 'hFFFF) byte_pos++;
    end
    if (it.last_of_packet) close_packet();
  endfunction

  // Output side: random stalls in bursts, result checking.
  int unsigned rx_burst = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (char_queue.size() == 0) begin
          $error("unexpected result code_point %0h", out_data_o.code_point);
          errors++;
        end else begin
          out_item_t e;
          e = char_queue.pop_front();
          if (out_data_o.code_point !== e.code_point) begin
            $error("code_point expected %0h actual %0h", e.code_point, out_data_o.code_point);
            errors++;
          end
          if (out_data_o.char_valid !== e.char_valid) begin
            $error("char_valid expected %0d actual %0d", e.char_valid, out_data_o.char_valid);
            errors++;
          end
          if (out_data_o.packet_status !== e.packet_status) begin
            $error("packet_status expected %0d actual %0d", e.packet_status,
                   out_data_o.packet_status);
            errors++;
          end
          if (out_data_o.last_result !== e.last_result) begin
            $error("last_result expected %0d actual %0d", e.last_result,
                   out_data_o.last_result);
            errors++;
          end
        end
      end
      if (rx_burst > 0) begin
        rx_burst--;
        out_stall_i <= (rx_burst > 0);
      end else if (rx_random && $urandom_range(7) == 0) begin
        rx_burst = $urandom_range(17, 1);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog on cycles with no accepted request or result.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Valid stays high after acceptance; a random idle gap before the next request or a drain wait takes it down.
  task automatic send_request(logic [7:0] b, bit present, logic [15:0] seq, bit first,
                              bit last);
    in_item_t it;
    it.data_byte = b;
    it.byte_present = present;
    it.sequence_number = seq;
    it.first_of_packet = first;
    it.last_of_packet = last;
    if (tx_random && $urandom_range(5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(17, 1)) @(posedge clk_i);
    end
    in_data_i <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_request(it);
  endtask

  task automatic send_packet(logic [7:0] bytes[$], logic [15:0] seq);
    if (bytes.size() == 0) begin
      send_request(8'($urandom), 1'b0, seq, 1'b1, 1'b1);
    end else begin
      for (int i = 0; i < bytes.size(); i++)
        send_request(bytes[i], 1'b1, seq, i == 0, i == bytes.size() - 1);
    end
    packets_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (char_queue.size() != 0) @(posedge clk_i);
    repeat (2 * BUFFER_BYTES + 20) @(posedge clk_i);
  endtask

  task automatic write_config(logic [6:0] text_val, logic [6:0] red_val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_TEXT_PT;
    cfg_wdata_i <= text_val;
    @(posedge clk_i);
    cfg_idx_i <= CFG_RED_PT;
    cfg_wdata_i <= red_val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    text_pt = text_val;
    red_pt = red_val;
  endtask

  // Random well-formed UTF-8 text, occasionally broken or with NUL/BOM.
  task automatic add_text(ref logic [7:0] q[$], input int chars);
    int unsigned k;
    for (int i = 0; i < chars; i++) begin
      k = $urandom_range(9);
      case (k)
        0: q.push_back(8'($urandom));
        1: begin
          q.push_back(8'hC0 | 8'($urandom_range(31)));
          q.push_back(8'h80 | 8'($urandom_range(63)));
        end
        2: begin
          q.push_back(8'hE0 | 8'($urandom_range(15)));
          q.push_back(8'h80 | 8'($urandom_range(63)));
          q.push_back(8'h80 | 8'($urandom_range(63)));
        end
        3: begin
          q.push_back(8'hF0 | 8'($urandom_range(7)));
          repeat (3) q.push_back(8'h80 | 8'($urandom_range(63)));
        end
        4: begin q.push_back(8'hEF); q.push_back(8'hBB); q.push_back(8'hBF); end
        5: q.push_back(8'h00);
        default: q.push_back(8'($urandom_range(127, 1)));
      endcase
    end
  endtask

  task automatic add_headers(ref logic [7:0] q[$], input int gens, ref int unsigned lens[$]);
    lens = {};
    for (int g = 0; g < gens; g++) begin
      int unsigned len;
      len = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(4);
      lens.push_back(len);
      q.push_back({1'b1, text_pt});
      q.push_back(8'($urandom));
      q.push_back({6'($urandom_range(63)), len[9:8]});
      q.push_back(len[7:0]);
    end
    q.push_back({1'b0, text_pt});
  endtask

  logic [15:0] seq_now = 0;

  task automatic test_plain_directed();
    logic [7:0] q[$];
    write_config(7'd0, 7'd0);
    q = {8'h41, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_packet(q, seq_now);
    seq_now++;
    q = {8'h00, 8'hEF, 8'hBB, 8'hBF, 8'h7F, 8'hFF};
    send_packet(q, seq_now);
    q = {8'h42};
    send_packet(q, 16'(seq_now + 3));   // loss inserts replacement
    seq_now = 16'(seq_now + 3);
    send_packet(q, 16'(seq_now - 2));   // out of order
    q = {8'h80};
    send_packet(q, 16'(seq_now + 1));
    q = {8'hE2, 8'h82};
    send_packet(q, 16'(seq_now + 1));   // truncated final character
    q = {};
    send_packet(q, 16'(seq_now + 1));   // empty packet
    seq_now++;
    q = {};
    for (int i = 0; i < 70; i++) q.push_back(8'(8'h61 + i % 20));
    send_packet(q, 16'(seq_now + 1));   // beyond capacity
    seq_now++;
    q = {8'h30};
    send_packet(q, 16'(seq_now - 200)); // large gap
    seq_now = 16'(seq_now - 200);
    wait_drained();
  endtask

  task automatic test_redundant_directed();
    logic [7:0] q[$];
    int unsigned lens[$];
    write_config(7'd127, 7'd127);
    q = {};
    add_headers(q, 2, lens);
    add_text(q, 6);
    seq_now++;
    send_packet(q, seq_now);
    q = {8'hFE, 8'h00, 8'h00, 8'h01, 8'h7F};   // wrong generation type
    send_packet(q, 16'(seq_now + 1));
    q = {8'hFF, 8'h00, 8'h00};                 // ends before primary header
    send_packet(q, 16'(seq_now + 1));
    q = {8'h7E};                               // wrong primary header
    send_packet(q, 16'(seq_now + 1));
    q = {};
    for (int g = 0; g < 9; g++) q = {q, 8'hFF, 8'h00, 8'h00, 8'h00};
    q.push_back(8'h7F);                        // too many generations
    send_packet(q, 16'(seq_now + 1));
    q = {8'hFF, 8'h00, 8'h03, 8'hFF, 8'h7F, 8'h41};  // skip past packet end
    send_packet(q, 16'(seq_now + 1));
    seq_now++;
    q = {8'hFF, 8'h00, 8'h00, 8'h01, 8'h7F, 8'h41, 8'h42};
    send_packet(q, 16'(seq_now + 5));          // loss beyond redundancy
    wait_drained();
  endtask

  task automatic test_random(int count, bit idle);
    logic [7:0] q[$];
    int unsigned lens[$];
    int unsigned sent, kind;
    sent = 0;
    tx_random = idle;
    rx_random = idle;
    while (sent < count) begin
      if ($urandom_range(9) == 0) begin
        wait_drained();
        write_config(7'($urandom_range(127)),
                     ($urandom_range(2) == 0) ? 7'd0 : 7'($urandom_range(127, 1)));
      end
      q = {};
      kind = $urandom_range(9);
      if (red_pt != 0 && kind < 8) add_headers(q, $urandom_range(MAX_GENERATIONS), lens);
      else if (kind == 9) repeat ($urandom_range(6)) q.push_back(8'($urandom));
      add_text(q, $urandom_range(6));
      case ($urandom_range(7))
        0: seq_now = 16'(seq_now - $urandom_range(120));
        1: seq_now = 16'($urandom);
        2: seq_now = 16'(seq_now + $urandom_range(12, 2));
        default: seq_now++;
      endcase
      if ($urandom_range(15) == 0) send_request(8'($urandom), 1'b1, seq_now, 1'b1, 1'b0); // dropped
      send_packet(q, seq_now);
      sent += (q.size() == 0) ? 1 : q.size();
    end
    wait_drained();
  endtask

  initial begin
    text_pt = 0; red_pt = 0; fill = 0; prev_seq = 0; cur_seq = 0; seen_first = 0;
    gen_cnt = 0; byte_pos = 0; skip_left = 0; pending = 0; pkt_err = 0; phase = PH_IDLE;
    foreach (txt_buf[i]) txt_buf[i] = 0;
    foreach (gen_len[i]) gen_len[i] = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_plain_directed();
    test_redundant_directed();
    test_random(60, 1'b1);
    test_random(30, 1'b0);
    wait_drained();
    $display("Covered %0d packets in plain and redundant mode, with loss, reorder,", packets_sent);
    $display("header, UTF-8 and length faults under random idling on both sides.");
    if (errors == 0 && char_queue.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
hw/rtl/rtt_pkg.sv
hw/rtl/rtt_ram.sv
hw/rtl/rtt_emit.sv
hw/rtl/rtt_redundant_text_receiver_top.sv
dv/tb_rtt_redundant_text_receiver_top.sv
